// ===== rtl/core/fsg_pkg.sv =====
// fsg_pkg: shared types and constants for the falling sand grid block
// cell codes, command codes, parameter defaults and controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package fsg_pkg;

  localparam int WIDTH_DEFAULT  = 256;
  localparam int HEIGHT_DEFAULT = 128;

  localparam logic [1:0] EMPTY = 2'd0;
  localparam logic [1:0] SAND  = 2'd1;
  localparam logic [1:0] WALL  = 2'd2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic clear;
    logic host;
    logic sweep_init;
    logic row_a;
    logic row_b;
    logic col;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic col_last;
    logic row_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/falling_sand_grid_step.sv =====
// falling_sand_grid_step: write, read and gravity sweep over a grid of cells.
// Write, read and no-op: result strobe one cycle after accept; the next command
// may be accepted in that same cycle. A step sweeps rows HEIGHT-2 down to 0,
// with one read-modify-write per cell on the row-parity banks, and its result
// strobes the cycle after the last row's flush. Results cannot be stalled.
// Reset: a clearing pass over every address of both banks, busy high.
`timescale 1ns / 1ps

module falling_sand_grid_step import fsg_pkg::*; #(
  parameter int WIDTH  = WIDTH_DEFAULT,
  parameter int HEIGHT = HEIGHT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [7:0] column,
  input  logic [6:0] row,
  input  logic [1:0] cell_kind,
  output logic       done,
  output logic [1:0] cell_value,
  output logic       was_step
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fsg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  fsg_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .column     (column),
    .row        (row),
    .cell_kind  (cell_kind),
    .cell_value (cell_value),
    .was_step   (was_step)
  );

endmodule

// ===== rtl/core/fsg_dp.sv =====
// fsg_dp: datapath of the falling sand grid, two row-parity memory banks,
// sweep window registers, row/column counters and the clearing counter
// depends on fsg_pkg
`timescale 1ns / 1ps

module fsg_dp import fsg_pkg::*; #(
  parameter int WIDTH  = WIDTH_DEFAULT,
  parameter int HEIGHT = HEIGHT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [1:0] command,
  input  logic [7:0] column,
  input  logic [6:0] row,
  input  logic [1:0] cell_kind,
  output logic [1:0] cell_value,
  output logic       was_step
);

  localparam int CW    = $clog2(WIDTH);
  localparam int RW    = $clog2(HEIGHT);
  localparam int RHW   = (RW > 1) ? RW - 1 : 1;
  localparam int AW    = RHW + CW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [CW-1:0] COL_LAST  = CW'(WIDTH - 1);
  localparam logic [RW-1:0] ROW_START = RW'(HEIGHT - 2);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [RHW-1:0] rh;
    rh = RHW'(r >> 1);
    return {rh, c};
  endfunction

  logic [1:0] mem0 [DEPTH];
  logic [1:0] mem1 [DEPTH];
  logic [1:0] q0, q1;

  logic          we0, we1;
  logic [AW-1:0] wa0, wa1, ra0, ra1;
  logic [1:0]    wd0, wd1;

  logic [AW-1:0] clr_addr;
  logic [CW-1:0] ccnt;
  logic [RW-1:0] rcnt;
  logic [1:0]    bl, bm;
  logic          resp_read, resp_bank, resp_step;

  logic          hb;
  logic [RW-1:0] rb;
  logic [1:0]    qh, qb;
  logic [1:0]    h_new, bl_new, bm_new, br_new;
  logic          first_col;

  logic          h_we, b_we;
  logic [AW-1:0] h_wa, b_wa, h_ra, b_ra;
  logic [1:0]    h_wd, b_wd;

  logic          host_in, host_wr;
  logic [AW-1:0] haddr;

  assign hb        = rcnt[0];
  assign rb        = rcnt + RW'(1);
  assign qh        = hb ? q1 : q0;
  assign qb        = hb ? q0 : q1;
  assign first_col = (ccnt == '0);

  assign stat.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.col_last   = (ccnt == COL_LAST);
  assign stat.row_last   = (rcnt == '0);

  assign host_in = (32'(column) < 32'(WIDTH)) && (32'(row) < 32'(HEIGHT));
  assign host_wr = (command == CMD_WRITE) && host_in && (cell_kind inside {EMPTY, SAND, WALL});
  assign haddr   = cell_addr(RW'(row), CW'(column));

  // one column of the sweep
  always_comb begin
    h_new  = qh;
    bl_new = bl;
    bm_new = bm;
    br_new = qb;
    if (qh == SAND) begin
      if (bm == EMPTY) begin
        bm_new = SAND;
        h_new  = EMPTY;
      end else if (!first_col && bl == EMPTY) begin
        bl_new = SAND;
        h_new  = EMPTY;
      end else if (!stat.col_last && qb == EMPTY) begin
        br_new = SAND;
        h_new  = EMPTY;
      end
    end
  end

  // here-row and below-row port roles
  always_comb begin
    h_we = 1'b0;
    h_wa = cell_addr(rcnt, ccnt);
    h_wd = h_new;
    h_ra = '0;
    b_we = 1'b0;
    b_wa = cell_addr(rb, ccnt - CW'(1));
    b_wd = bl_new;
    b_ra = '0;
    if (cmd.row_a) begin
      b_ra = cell_addr(rb, '0);
    end else if (cmd.row_b) begin
      b_ra = cell_addr(rb, CW'(1));
      h_ra = cell_addr(rcnt, '0);
    end else if (cmd.col) begin
      h_we = 1'b1;
      b_we = !first_col;
      h_ra = cell_addr(rcnt, ccnt + CW'(1));
      b_ra = cell_addr(rb, ccnt + CW'(2));
    end else if (cmd.flush) begin
      b_we = 1'b1;
      b_wa = cell_addr(rb, COL_LAST);
      b_wd = bl;
    end
  end

  // bank port selection
  always_comb begin
    if (cmd.clear) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wa0 = clr_addr;
      wa1 = clr_addr;
      wd0 = EMPTY;
      wd1 = EMPTY;
      ra0 = '0;
      ra1 = '0;
    end else if (cmd.host) begin
      we0 = host_wr && !row[0];
      we1 = host_wr && row[0];
      wa0 = haddr;
      wa1 = haddr;
      wd0 = cell_kind;
      wd1 = cell_kind;
      ra0 = haddr;
      ra1 = haddr;
    end else if (hb) begin
      we0 = b_we;
      wa0 = b_wa;
      wd0 = b_wd;
      ra0 = b_ra;
      we1 = h_we;
      wa1 = h_wa;
      wd1 = h_wd;
      ra1 = h_ra;
    end else begin
      we0 = h_we;
      wa0 = h_wa;
      wd0 = h_wd;
      ra0 = h_ra;
      we1 = b_we;
      wa1 = b_wa;
      wd1 = b_wd;
      ra1 = b_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    q0 <= mem0[ra0];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    q1 <= mem1[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      resp_read <= 1'b0;
      resp_step <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.host) begin
        resp_read <= (command == CMD_READ) && host_in;
        resp_step <= (command == CMD_STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.host) begin
      resp_bank <= row[0];
    end
    if (cmd.sweep_init) begin
      rcnt <= ROW_START;
    end else if (cmd.flush && !stat.row_last) begin
      rcnt <= rcnt - RW'(1);
    end
    if (cmd.row_b) begin
      ccnt <= '0;
      bm   <= qb;
    end else if (cmd.col) begin
      ccnt <= ccnt + CW'(1);
      bl   <= bm_new;
      bm   <= br_new;
    end
  end

  assign cell_value = resp_read ? (resp_bank ? q1 : q0) : EMPTY;
  assign was_step   = resp_step;

endmodule

// ===== rtl/core/fsg_ctrl.sv =====
// fsg_ctrl: controller state machine of the falling sand grid
// sequences the clearing pass, host beats and the row-by-row sweep
// depends on fsg_pkg
`timescale 1ns / 1ps

module fsg_ctrl import fsg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW_A,
    S_ROW_B,
    S_COL,
    S_FLUSH
  } state_t;

  state_t state;

  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd            = '0;
    cmd.clear      = (state == S_CLEAR);
    cmd.host       = accept;
    cmd.sweep_init = accept && (command == CMD_STEP);
    cmd.row_a      = (state == S_ROW_A);
    cmd.row_b      = (state == S_ROW_B);
    cmd.col        = (state == S_COL);
    cmd.flush      = (state == S_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (command == CMD_STEP) begin
              state <= S_ROW_A;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_ROW_A: state <= S_ROW_B;
        S_ROW_B: state <= S_COL;
        S_COL: begin
          if (stat.col_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (stat.row_last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_ROW_A;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && stat.row_last) |=> (done && !busy))
    else $error("sweep end without result beat");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept && command != CMD_STEP) || $past(state == S_FLUSH)))
    else $error("result beat without cause");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && stat.clear_last) |=> (!busy && !done))
    else $error("clearing pass did not end in idle");

  a_no_host_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (cmd.row_a || cmd.row_b || cmd.col || cmd.flush || cmd.clear) |-> !cmd.host)
    else $error("host beat during sweep or clear");
`endif

endmodule

// ===== tb/sv/falling_sand_grid_step_tb.sv =====
// falling_sand_grid_step_tb: self-checking bench for the falling sand grid block
// directed table, then random clusters, sweeps and lone commands, checked against grid model
// depends on fsg_pkg and falling_sand_grid_step
`timescale 1ns / 1ps

module falling_sand_grid_step_tb import fsg_pkg::*; ();

  localparam int GRID_W = WIDTH_DEFAULT;
  localparam int GRID_H = HEIGHT_DEFAULT;
  localparam logic [1:0] CMD_NOP  = 2'd3;
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam int RANDOM_ITEMS = 70;
  localparam int RANDOM_SWEEPS = 8;
  localparam int STALL_LIMIT = 150000;

  typedef struct {
    logic [1:0] value;
    logic       stepped;
  } reply_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] col;
    logic [6:0] rw;
    logic [1:0] kind;
    bit         typed;
    logic [1:0] value;
    logic       stepped;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] command;
  logic [7:0] column;
  logic [6:0] row;
  logic [1:0] cell_kind;
  logic       done;
  logic [1:0] cell_value;
  logic       was_step;

  logic [1:0] cell_model [GRID_H][GRID_W];
  reply_t     awaited[$];
  stim_row_t  stim_table[$];
  reply_t     head;
  int         errors;
  int         stall_count;
  bit         calm;

  falling_sand_grid_step u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .column     (column),
    .row        (row),
    .cell_kind  (cell_kind),
    .done       (done),
    .cell_value (cell_value),
    .was_step   (was_step)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void gravity_sweep();
    for (int r = GRID_H - 2; r >= 0; r--) begin
      for (int c = 0; c < GRID_W; c++) begin
        if (cell_model[r][c] == SAND) begin
          if (cell_model[r+1][c] == EMPTY) begin
            cell_model[r+1][c] = SAND;
            cell_model[r][c] = EMPTY;
          end else if (c > 0 && cell_model[r+1][c-1] == EMPTY) begin
            cell_model[r+1][c-1] = SAND;
            cell_model[r][c] = EMPTY;
          end else if (c + 1 < GRID_W && cell_model[r+1][c+1] == EMPTY) begin
            cell_model[r+1][c+1] = SAND;
            cell_model[r][c] = EMPTY;
          end
        end
      end
    end
  endfunction

  function automatic reply_t apply_command(input logic [1:0] cmd, input logic [7:0] col,
                                           input logic [6:0] rw, input logic [1:0] kind);
    reply_t r;
    bit     on_grid;
    r.value = EMPTY;
    r.stepped = 1'b0;
    on_grid = int'(col) < GRID_W && int'(rw) < GRID_H;
    case (cmd)
      CMD_WRITE: begin
        if (on_grid && kind <= WALL) cell_model[rw][col] = kind;
      end
      CMD_STEP: begin
        gravity_sweep();
        r.stepped = 1'b1;
      end
      CMD_READ: begin
        if (on_grid) r.value = cell_model[rw][col];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int near_col(input int base);
    int c;
    c = base + int'($urandom_range(2)) - 1;
    if (c < 0) c = 0;
    if (c > GRID_W - 1) c = GRID_W - 1;
    return c;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int col, input int rw,
                         input logic [1:0] kind, input bit typed = 0,
                         input logic [1:0] value = EMPTY, input logic stepped = 1'b0);
    stim_row_t s;
    s.cmd = cmd;
    s.col = 8'(col);
    s.rw = 7'(rw);
    s.kind = kind;
    s.typed = typed;
    s.value = value;
    s.stepped = stepped;
    stim_table.push_back(s);
  endtask

  task automatic hold_off();
    int n;
    if (!calm && $urandom_range(99) < 35) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // one beat: present the command, wait until accepted, record what should come back
  task automatic send(input logic [1:0] cmd, input logic [7:0] col, input logic [6:0] rw,
                      input logic [1:0] kind, input bit typed = 0,
                      input logic [1:0] value = EMPTY, input logic stepped = 1'b0);
    reply_t r;
    hold_off();
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    column <= col;
    row <= rw;
    cell_kind <= kind;
    do @(posedge clk); while (busy);
    r = apply_command(cmd, col, rw, kind);
    if (typed) begin
      r.value = value;
      r.stepped = stepped;
    end
    awaited.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: value %0d step %0d",
                         cell_value, was_step));
      end else begin
        head = awaited.pop_front();
        if (cell_value !== head.value)
          report($sformatf("cell_value got %0d expected %0d", cell_value, head.value));
        if (was_step !== head.stepped)
          report($sformatf("was_step got %0d expected %0d", was_step, head.stepped));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("falling_sand_grid_step verification failed");
        $finish;
      end
    end
  end

  initial begin
    int sweeps_left;
    int n;
    int base_c;
    int base_r;
    int rand_count;
    logic [1:0] cmd;
    logic [1:0] kind;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_NOP;
    column = '0;
    row = '0;
    cell_kind = EMPTY;
    errors = 0;
    calm = 0;
    for (int r = 0; r < GRID_H; r++)
      for (int c = 0; c < GRID_W; c++)
        cell_model[r][c] = EMPTY;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset contents, extremes, ignored kind, unused command
    add_row(CMD_READ, 0, 0, EMPTY, 1, EMPTY, 1'b0);
    add_row(CMD_READ, 255, 127, EMPTY, 1, EMPTY, 1'b0);
    add_row(CMD_WRITE, 255, 127, SAND, 1, EMPTY, 1'b0);
    add_row(CMD_READ, 255, 127, EMPTY, 1, SAND, 1'b0);
    add_row(CMD_WRITE, 0, 0, WALL, 1, EMPTY, 1'b0);
    add_row(CMD_WRITE, 0, 0, KIND_BAD, 1, EMPTY, 1'b0);
    add_row(CMD_READ, 0, 0, EMPTY, 1, WALL, 1'b0);
    add_row(CMD_NOP, 255, 127, KIND_BAD, 1, EMPTY, 1'b0);
    // straight down
    add_row(CMD_WRITE, 10, 125, SAND);
    // blocked below, goes down-left
    add_row(CMD_WRITE, 20, 126, WALL);
    add_row(CMD_WRITE, 20, 125, SAND);
    // blocked below and left, goes down-right
    add_row(CMD_WRITE, 29, 126, WALL);
    add_row(CMD_WRITE, 30, 126, WALL);
    add_row(CMD_WRITE, 30, 125, SAND);
    // right edge, nowhere to go
    add_row(CMD_WRITE, 254, 127, WALL);
    add_row(CMD_WRITE, 255, 126, SAND);
    // top row sand
    add_row(CMD_WRITE, 128, 0, SAND);
    add_row(CMD_STEP, 0, 0, EMPTY, 1, EMPTY, 1'b1);
    add_row(CMD_READ, 10, 126, EMPTY);
    add_row(CMD_READ, 19, 126, EMPTY);
    add_row(CMD_READ, 31, 126, EMPTY);
    add_row(CMD_READ, 255, 126, EMPTY);
    add_row(CMD_READ, 255, 127, EMPTY);
    add_row(CMD_READ, 128, 1, EMPTY);

    foreach (stim_table[i])
      send(stim_table[i].cmd, stim_table[i].col, stim_table[i].rw, stim_table[i].kind,
           stim_table[i].typed, stim_table[i].value, stim_table[i].stepped);

    // let everything drain before the random part
    @(negedge clk);
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);

    sweeps_left = RANDOM_SWEEPS;
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      calm = rand_count >= 30 && rand_count < 60;
      if ($urandom_range(99) < 75) begin
        // a small cluster of cells, maybe a sweep, then reads around it
        case ($urandom_range(3))
          0: base_c = 0;
          1: base_c = GRID_W - 1;
          default: base_c = $urandom_range(GRID_W - 1);
        endcase
        base_r = $urandom_range(1) ? GRID_H - 3 : $urandom_range(GRID_H - 3);
        n = $urandom_range(3, 8);
        repeat (n) begin
          n = $urandom_range(9);
          kind = n < 7 ? SAND : (n < 9 ? WALL : EMPTY);
          send(CMD_WRITE, 8'(near_col(base_c)), 7'(base_r + int'($urandom_range(2))), kind);
          rand_count++;
        end
        if (sweeps_left > 0 && $urandom_range(2) != 0) begin
          send(CMD_STEP, 8'($urandom_range(GRID_W - 1)), 7'($urandom_range(GRID_H - 1)),
               2'($urandom_range(3)));
          sweeps_left--;
          rand_count++;
        end
        n = $urandom_range(2, 5);
        repeat (n) begin
          send(CMD_READ, 8'(near_col(base_c)), 7'(base_r + int'($urandom_range(2))),
               2'($urandom_range(3)));
          rand_count++;
        end
      end else begin
        cmd = 2'($urandom_range(2));
        if (cmd == CMD_STEP) cmd = CMD_NOP;
        send(cmd, 8'($urandom_range(GRID_W - 1)), 7'($urandom_range(GRID_H - 1)),
             2'($urandom_range(3)));
        rand_count++;
      end
    end
    calm = 0;

    @(negedge clk);
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("falling_sand_grid_step verification clean");
    end else begin
      $display("falling_sand_grid_step verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fsg_pkg.sv
rtl/core/fsg_dp.sv
rtl/core/fsg_ctrl.sv
rtl/core/falling_sand_grid_step.sv
tb/sv/falling_sand_grid_step_tb.sv
